/* design/pvaos_pkg.sv */
// Shared types and constants for the voice allocator.
// Word formats for both channels, func codes, controller/datapath handshake structs.
`timescale 1ns / 1ps

package pvaos_pkg;

	localparam int VOICES_DEF = 32;
	localparam int MAX_BLOCK  = 4096;

	localparam int FUNC_W  = 3;
	localparam int NOTE_W  = 7;
	localparam int OFF_W   = 12;
	localparam int POS_W   = 48;
	localparam int VIDX_W  = 5;
	localparam int SLOT_W  = 5;
	localparam int MASK_W  = 32;
	localparam int COUNT_W = 6;
	localparam int REL_W   = OFF_W + 1;

	localparam logic [FUNC_W-1:0] FUNC_NOTE_ON     = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_BLOCK_OPEN  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_BLOCK_CLOSE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_VOICE_DONE  = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [NOTE_W-1:0] note_number;
		logic [OFF_W-1:0]  offset_in_block;
		logic [POS_W-1:0]  block_base;
		logic [VIDX_W-1:0] voice_index;
	} event_word_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic               stolen;
		logic [MASK_W-1:0]  release_mask;
		logic [COUNT_W-1:0] busy_count;
		logic               drain;
		logic               error;
	} result_word_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic scan_start;
		logic scan_step;
		logic commit;
		logic steal;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_scan;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

/* design/poly_voice_allocator_oldest_steal_core.sv */
// Polyphonic voice allocator with oldest-voice stealing, top level.
// Instantiates pvaos_ctrl and pvaos_dp; depends on pvaos_pkg.
//
// Usage notes:
//  - event channel (event_valid/event_ready/event_word) takes one word per
//    event: note on, note off, block open, block close or voice done.
//  - result channel (result_valid/result_ready/result_word) returns exactly
//    one word per event; fields that do not apply to the event read zero.
//  - Timing: an event is captured in IDLE and committed from EXEC once the
//    output register is free; result_valid rises after the commit, and no
//    new event is accepted until the current one is committed.
//  - A note on that finds every slot busy walks the start-time table one
//    slot per cycle through a single 48-bit comparator, then commits the
//    steal of the oldest slot.
//  - The output register decouples the sides: the next event is accepted
//    while a result waits; a stalled receiver only holds up the commit.
//  - Reset (arst_n low) frees all slots, clears release marks, the steal
//    flag and the voice count; no clearing pass is needed.
`timescale 1ns / 1ps

module poly_voice_allocator_oldest_steal_core
	import pvaos_pkg::*;
#(
	parameter int VOICES = VOICES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         event_valid,
	output logic         event_ready,
	input  event_word_t  event_word,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result_word
);

	// command/status between sequencer and datapath
	dp_cmd_t    cmd;
	dp_status_t status;

	pvaos_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.status      (status),
		.cmd         (cmd)
	);

	// slot table, scan unit and result register
	pvaos_dp #(
		.VOICES (VOICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.event_word   (event_word),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

endmodule

/* design/pvaos_ctrl.sv */
// Sequencing state machine of the voice allocator.
// Depends on pvaos_pkg for the command and status structs.
`timescale 1ns / 1ps

module pvaos_ctrl
	import pvaos_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       event_valid,
	output logic       event_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		event_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (event_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.need_scan) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					cmd.steal  = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* design/pvaos_dp.sv */
// Datapath of the voice allocator: slot table, oldest-voice scan, output register.
// Depends on pvaos_pkg for word formats, func codes and control structs.
`timescale 1ns / 1ps

module pvaos_dp
	import pvaos_pkg::*;
#(
	parameter int VOICES = VOICES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  event_word_t  event_word,
	input  dp_cmd_t      cmd,
	output dp_status_t   status,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result_word
);

	localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW = $clog2(VOICES + 1);

	// captured event
	logic [FUNC_W-1:0] func_q;
	logic [NOTE_W-1:0] note_q;
	logic [OFF_W-1:0]  off_q;
	logic [POS_W-1:0]  time_q;
	logic [VIDX_W-1:0] vidx_q;

	// slot table
	logic [VOICES-1:0] in_use_q;
	logic [VOICES-1:0] rel_now_q;
	logic [VOICES-1:0] rel_before_q;
	logic [NOTE_W-1:0] slot_note_q  [VOICES];
	logic [REL_W-1:0]  rel_off_q    [VOICES];
	logic [OFF_W-1:0]  start_blk_q  [VOICES];
	logic [POS_W-1:0]  start_time_q [VOICES];
	logic              sticky_q;
	logic [CW-1:0]     count_q;

	// oldest-voice scan
	logic [IW-1:0]    cnt_q;
	logic [IW-1:0]    pick_q;
	logic [POS_W-1:0] best_q;

	logic              out_valid_q;
	result_word_t      out_word_q;

	logic [OFF_W-1:0]  off_clamp;
	logic [VOICES-1:0] hit;
	logic [IW-1:0]     free_pick;
	logic              any_free;
	logic [IW-1:0]     pick;
	logic              done_ok;
	logic [IW-1:0]     done_idx;
	logic [POS_W-1:0]  st_rd;
	logic              scan_last;
	result_word_t      res;

	assign off_clamp = ({1'b0, event_word.offset_in_block} >= REL_W'(MAX_BLOCK)) ?
		OFF_W'(MAX_BLOCK - 1) : event_word.offset_in_block;

	always_comb begin
		free_pick = '0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (!in_use_q[v]) begin
				free_pick = IW'(v);
			end
		end
	end

	always_comb begin
		for (int v = 0; v < VOICES; v++) begin
			hit[v] = in_use_q[v] & ~rel_before_q[v] & (slot_note_q[v] == note_q);
		end
	end

	assign any_free  = ~&in_use_q;
	assign pick      = cmd.steal ? pick_q : free_pick;
	assign done_idx  = IW'(vidx_q);
	assign done_ok   = ({1'b0, vidx_q} < (VIDX_W + 1)'(VOICES)) && in_use_q[done_idx];
	assign st_rd     = start_time_q[cnt_q];
	assign scan_last = (cnt_q == IW'(VOICES - 1));

	assign status.need_scan = (func_q == FUNC_NOTE_ON) && !any_free;
	assign status.scan_last = scan_last;
	assign status.out_free  = !out_valid_q || result_ready;

	always_comb begin
		res = '0;
		case (func_q)
			FUNC_NOTE_ON: begin
				res.slot   = SLOT_W'(pick);
				res.stolen = cmd.steal;
			end
			FUNC_NOTE_OFF: begin
				res.release_mask = MASK_W'(hit);
			end
			FUNC_BLOCK_CLOSE: begin
				res.busy_count = COUNT_W'(count_q);
				res.drain      = sticky_q;
			end
			FUNC_VOICE_DONE: begin
				res.error = !done_ok;
			end
			default: begin
			end
		endcase
	end

	// control state and reset-valued table marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q     <= '0;
			rel_now_q    <= '0;
			rel_before_q <= '0;
			sticky_q     <= 1'b0;
			count_q      <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			for (int v = 0; v < VOICES; v++) begin
				rel_off_q[v] <= '1;
			end
		end else begin
			if (cmd.scan_start) begin
				cnt_q <= '0;
			end else if (cmd.scan_step && !scan_last) begin
				cnt_q <= cnt_q + IW'(1);
			end

			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.commit) begin
				case (func_q)
					FUNC_NOTE_ON: begin
						in_use_q[pick]     <= 1'b1;
						rel_now_q[pick]    <= 1'b0;
						rel_before_q[pick] <= 1'b0;
						rel_off_q[pick]    <= '1;
						if (cmd.steal) begin
							sticky_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
					FUNC_NOTE_OFF: begin
						for (int v = 0; v < VOICES; v++) begin
							if (hit[v]) begin
								rel_now_q[v] <= 1'b1;
								rel_off_q[v] <= {1'b0, off_q};
							end
						end
					end
					FUNC_BLOCK_OPEN: begin
						rel_now_q <= rel_now_q & ~in_use_q;
						sticky_q  <= 1'b0;
					end
					FUNC_BLOCK_CLOSE: begin
						rel_before_q <= rel_before_q | (in_use_q & rel_now_q);
					end
					FUNC_VOICE_DONE: begin
						if (done_ok) begin
							in_use_q[done_idx]     <= 1'b0;
							rel_now_q[done_idx]    <= 1'b0;
							rel_before_q[done_idx] <= 1'b0;
							rel_off_q[done_idx]    <= '1;
							count_q                <= count_q - CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// payload: captured event, per-slot data, scan best, result word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= event_word.func;
			note_q <= event_word.note_number;
			off_q  <= off_clamp;
			time_q <= event_word.block_base + POS_W'(off_clamp);
			vidx_q <= event_word.voice_index;
		end

		// strict less-than keeps the lowest index on ties
		if (cmd.scan_step && (cnt_q == '0 || st_rd < best_q)) begin
			best_q <= st_rd;
			pick_q <= cnt_q;
		end

		if (cmd.commit) begin
			out_word_q <= res;
			case (func_q)
				FUNC_NOTE_ON: begin
					slot_note_q[pick]  <= note_q;
					start_blk_q[pick]  <= off_q;
					start_time_q[pick] <= time_q;
				end
				FUNC_BLOCK_OPEN: begin
					for (int v = 0; v < VOICES; v++) begin
						if (in_use_q[v]) begin
							start_blk_q[v] <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result_word  = out_word_q;

endmodule
